// ===== hw/rtl/kcct_pkg.sv =====
// ----------------------------------------------------------------------------
// kcct_pkg
// Shared types and constants for the key chord capture tracker.
// ----------------------------------------------------------------------------
package kcct_pkg;

    localparam int MAX_KEYS = 8;
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CMP_W    = CNT_W + 4;
    localparam int HELD_W   = 9;
    localparam int KEY_W    = 8;
    localparam int RIDX_W   = 3;
    localparam int RLIM_W   = 4;
    localparam int CAPT_W   = 4;
    localparam int KEYS     = 256;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 24;
    localparam int USER_W   = 2;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PRESS   = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic fetch;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  held;
        logic  scan_end;
        logic  list_full;
    } sts_t;

endpackage

// ===== hw/rtl/kcct_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcct_ctrl
// Sequencer: fetch of the held bit, list scan on new presses, result commit.
// ----------------------------------------------------------------------------
module kcct_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  kcct_pkg::sts_t  sts,
    output kcct_pkg::cmd_t  cmd
);

    kcct_pkg::state_t state_reg;
    kcct_pkg::state_t state_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic             out_free;

    assign out_free = !out_vld_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kcct_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = kcct_pkg::ST_FETCH;
            end
            kcct_pkg::ST_FETCH:
                state_next = kcct_pkg::ST_EVAL;
            kcct_pkg::ST_EVAL:
            begin
                if (sts.mode == kcct_pkg::MODE_PRESS && !sts.held && !sts.list_full)
                    state_next = kcct_pkg::ST_SCAN;
                else
                    state_next = kcct_pkg::ST_FINISH;
            end
            kcct_pkg::ST_SCAN:
            begin
                if (sts.scan_end)
                    state_next = kcct_pkg::ST_FINISH;
            end
            kcct_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = kcct_pkg::ST_IDLE;
            end
            default:
                state_next = kcct_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        s_tready     = 1'b0;
        out_vld_next = out_vld_reg && !m_tready;
        case (state_reg)
            kcct_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            kcct_pkg::ST_FETCH:
                cmd.fetch = 1'b1;
            kcct_pkg::ST_EVAL:
                cmd = '0;
            kcct_pkg::ST_SCAN:
                cmd.scan_step = !sts.scan_end;
            kcct_pkg::ST_FINISH:
            begin
                cmd.commit = out_free;
                if (out_free)
                    out_vld_next = 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

    assign m_tvalid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kcct_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

// ===== hw/rtl/kcct_dp.sv =====
// ----------------------------------------------------------------------------
// kcct_dp
// Datapath: held-key memory, held/captured counts, captured list, result word.
// ----------------------------------------------------------------------------
module kcct_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [kcct_pkg::IN_W-1:0]     s_tdata,
    input  logic [kcct_pkg::USER_W-1:0]   s_tuser,
    output logic [kcct_pkg::OUT_W-1:0]    m_tdata,
    input  kcct_pkg::cmd_t                cmd,
    output kcct_pkg::sts_t                sts
);

    kcct_pkg::mode_t                 mode_reg;
    logic [kcct_pkg::KEY_W-1:0]      key_reg;
    logic [kcct_pkg::RIDX_W-1:0]     ridx_reg;
    logic [kcct_pkg::RLIM_W-1:0]     rlim_reg;

    logic                            held_mem [kcct_pkg::KEYS];
    logic                            held_mem_rd_reg;
    logic [kcct_pkg::KEYS-1:0]       held_vld_reg;
    logic                            held_vld_rd_reg;
    logic                            held;

    logic [kcct_pkg::HELD_W-1:0]     held_cnt_reg;
    logic [kcct_pkg::HELD_W-1:0]     held_cnt_next;
    logic [kcct_pkg::CNT_W-1:0]      cap_cnt_reg;
    logic [kcct_pkg::CNT_W-1:0]      cap_cnt_next;
    logic [kcct_pkg::KEY_W-1:0]      cap_list_reg [kcct_pkg::MAX_KEYS];
    logic [kcct_pkg::CNT_W-1:0]      scan_idx_reg;
    logic                            listed_reg;

    logic                            is_clear;
    logic                            is_press;
    logic                            is_release;
    logic                            is_read;
    logic                            new_hold;
    logic                            drop_hold;
    logic                            append;
    logic                            list_full;
    logic                            newly;
    logic                            done;
    logic                            evalid;
    logic [kcct_pkg::KEY_W-1:0]      ekey;

    logic                            newly_reg;
    logic                            done_reg;
    logic [kcct_pkg::HELD_W-1:0]     held_tot_reg;
    logic [kcct_pkg::CAPT_W-1:0]     capt_tot_reg;
    logic [kcct_pkg::KEY_W-1:0]      ekey_reg;
    logic                            evalid_reg;

    assign is_clear   = mode_reg == kcct_pkg::MODE_CLEAR;
    assign is_press   = mode_reg == kcct_pkg::MODE_PRESS;
    assign is_release = mode_reg == kcct_pkg::MODE_RELEASE;
    assign is_read    = mode_reg == kcct_pkg::MODE_READ;

    assign held      = held_vld_rd_reg && held_mem_rd_reg;
    assign list_full = cap_cnt_reg == kcct_pkg::CNT_W'(kcct_pkg::MAX_KEYS);
    assign new_hold  = is_press && !held;
    assign drop_hold = is_release && held;
    assign append    = new_hold && !list_full && !listed_reg;

    assign sts.mode      = mode_reg;
    assign sts.held      = held;
    assign sts.scan_end  = scan_idx_reg == cap_cnt_reg;
    assign sts.list_full = list_full;

    always_comb
    begin
        held_cnt_next = held_cnt_reg;
        cap_cnt_next  = cap_cnt_reg;
        if (is_clear)
        begin
            held_cnt_next = '0;
            cap_cnt_next  = '0;
        end
        else
        begin
            if (new_hold && held_cnt_reg != kcct_pkg::HELD_W'(kcct_pkg::KEYS))
                held_cnt_next = held_cnt_reg + 1'b1;
            if (drop_hold && held_cnt_reg != '0)
                held_cnt_next = held_cnt_reg - 1'b1;
            if (append)
                cap_cnt_next = cap_cnt_reg + 1'b1;
        end
    end

    assign newly  = new_hold;
    assign done   = drop_hold && held_cnt_next == '0 && cap_cnt_reg != '0;
    assign evalid = is_read
                    && kcct_pkg::CMP_W'(ridx_reg) < kcct_pkg::CMP_W'(cap_cnt_reg)
                    && kcct_pkg::CMP_W'(ridx_reg) < kcct_pkg::CMP_W'(rlim_reg);
    assign ekey   = evalid ? cap_list_reg[kcct_pkg::IDX_W'(ridx_reg)] : '0;

    // held-key memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.commit && new_hold)
            held_mem[key_reg] <= 1'b1;
        else if (cmd.commit && drop_hold)
            held_mem[key_reg] <= 1'b0;
        if (cmd.fetch)
            held_mem_rd_reg <= held_mem[key_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_vld_reg <= '0;
            held_cnt_reg <= '0;
            cap_cnt_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            held_cnt_reg <= held_cnt_next;
            cap_cnt_reg  <= cap_cnt_next;
            if (is_clear)
                held_vld_reg <= '0;
            else if (new_hold)
                held_vld_reg[key_reg] <= 1'b1;
            else if (drop_hold)
                held_vld_reg[key_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= kcct_pkg::mode_t'(s_tuser);
            key_reg      <= s_tdata[7:0];
            ridx_reg     <= s_tdata[10:8];
            rlim_reg     <= s_tdata[14:11];
            scan_idx_reg <= '0;
            listed_reg   <= 1'b0;
        end
        if (cmd.fetch)
            held_vld_rd_reg <= held_vld_reg[key_reg];
        if (cmd.scan_step)
        begin
            if (cap_list_reg[scan_idx_reg[kcct_pkg::IDX_W-1:0]] == key_reg)
                listed_reg <= 1'b1;
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            if (!is_clear && append)
                cap_list_reg[cap_cnt_reg[kcct_pkg::IDX_W-1:0]] <= key_reg;
            newly_reg    <= newly;
            done_reg     <= done;
            held_tot_reg <= held_cnt_next;
            capt_tot_reg <= kcct_pkg::CAPT_W'(cap_cnt_next);
            ekey_reg     <= ekey;
            evalid_reg   <= evalid;
        end
    end

    assign m_tdata = {evalid_reg, ekey_reg, capt_tot_reg, held_tot_reg, done_reg, newly_reg};

endmodule

// ===== hw/rtl/key_chord_capture_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// key_chord_capture_tracker_unit
// Key chord capture tracker: held-key bitmap, held count, captured key list.
//
// channel  dir  handshake           payload
// s        in   s_tvalid/s_tready   s_tuser: mode; s_tdata: key_code, read_index, read_limit
// m        out  m_tvalid/m_tready   m_tdata: one result word per input word
//
// One word at a time. Clear, release, read and a press that needs no list scan
// go from accept through fetch and evaluate to the commit of the result word;
// a press of a key not held with room in the list first scans the captured
// list one entry a cycle. The held bit comes from a 256x1 memory with a
// registered read. Reset clears the held-valid bitmap and both counts at once,
// no clearing pass. A stalled result word holds in the output register; the
// next input word is accepted meanwhile and waits for it before committing.
// ----------------------------------------------------------------------------
module key_chord_capture_tracker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kcct_pkg::IN_W-1:0]     s_tdata,  // key_code, read_index, read_limit, pad
    input  logic [kcct_pkg::USER_W-1:0]   s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kcct_pkg::OUT_W-1:0]    m_tdata   // newly_held, capture_done, held_total,
                                                    // captured_total, entry_key, entry_valid
);

    kcct_pkg::cmd_t cmd;
    kcct_pkg::sts_t sts;

    kcct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kcct_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[10:2] != 9'd0))
        else $error("new hold with zero held total");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[10:2] == 9'd0 && !m_tdata[0]))
        else $error("capture done with keys still held");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (sts.mode != kcct_pkg::MODE_PRESS || sts.held || sts.list_full
                        || sts.scan_end))
        else $error("commit before list scan finished");
`endif

endmodule

// ===== bench/tb_key_chord_capture_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_key_chord_capture_tracker_unit
// Self-checking bench for the key chord capture tracker. Words go in on the
// slave stream with random gaps. A local model of the held bitmap, held count
// and captured list predicts each result word. Result words are taken from
// the master stream under random back-pressure and checked field by field.
// ----------------------------------------------------------------------------
module tb_key_chord_capture_tracker_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WD_LIMIT = 5000;

    // m_tdata layout, high bit first
    typedef struct packed {
        logic       entry_valid;
        logic [7:0] entry_key;
        logic [3:0] captured_total;
        logic [8:0] held_total;
        logic       capture_done;
        logic       newly_held;
    } result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [kcct_pkg::IN_W-1:0]     s_tdata;
    logic [kcct_pkg::USER_W-1:0]   s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [kcct_pkg::OUT_W-1:0]    m_tdata;

    // model state
    logic [kcct_pkg::KEYS-1:0]     held_map;
    int                            held_cnt;
    logic [7:0]                    cap_list [kcct_pkg::MAX_KEYS];
    int                            cap_cnt;

    result_t             expected_words [$];
    int                  mismatch_cnt;
    int                  sent_cnt;
    int                  stall_left;
    int                  idle_cycles;
    bit                  idle_en;

    key_chord_capture_tracker_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic result_t track_keys(input kcct_pkg::mode_t md, input logic [7:0] key,
                                           input logic [2:0] ridx, input logic [3:0] rlim);
        result_t r;
        logic    listed;
        r = '0;
        listed = 1'b0;
        case (md)
            kcct_pkg::MODE_CLEAR:
            begin
                held_map = '0;
                held_cnt = 0;
                cap_cnt  = 0;
                foreach (cap_list[i])
                    cap_list[i] = 8'd0;
            end
            kcct_pkg::MODE_PRESS:
            begin
                if (!held_map[key])
                begin
                    held_map[key] = 1'b1;
                    if (held_cnt < 256)
                        held_cnt++;
                    r.newly_held = 1'b1;
                    if (cap_cnt < kcct_pkg::MAX_KEYS)
                    begin
                        for (int i = 0; i < cap_cnt; i++)
                            if (cap_list[i] == key)
                                listed = 1'b1;
                        if (!listed)
                        begin
                            cap_list[cap_cnt] = key;
                            cap_cnt++;
                        end
                    end
                end
            end
            kcct_pkg::MODE_RELEASE:
            begin
                if (held_map[key])
                begin
                    held_map[key] = 1'b0;
                    if (held_cnt > 0)
                        held_cnt--;
                    r.capture_done = (held_cnt == 0) && (cap_cnt > 0);
                end
            end
            default:
            begin
                if (int'(ridx) < cap_cnt && int'(ridx) < int'(rlim)
                    && int'(ridx) < kcct_pkg::MAX_KEYS)
                begin
                    r.entry_valid = 1'b1;
                    r.entry_key   = cap_list[ridx];
                end
            end
        endcase
        r.held_total     = 9'(held_cnt);
        r.captured_total = 4'(cap_cnt);
        return r;
    endfunction

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(input kcct_pkg::mode_t md, input logic [7:0] key,
                             input logic [2:0] ridx, input logic [3:0] rlim);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, rlim, ridx, key};
        s_tuser  <= md;
        do
            @(posedge clk);
        while (!s_tready);
        expected_words.push_back(track_keys(md, key, ridx, rlim));
        sent_cnt++;
    endtask

    task automatic press(input logic [7:0] key);
        send_word(kcct_pkg::MODE_PRESS, key, 3'($urandom), 4'($urandom));
    endtask

    task automatic release_key(input logic [7:0] key);
        send_word(kcct_pkg::MODE_RELEASE, key, 3'($urandom), 4'($urandom));
    endtask

    task automatic read_entry(input logic [2:0] ridx, input logic [3:0] rlim);
        send_word(kcct_pkg::MODE_READ, 8'($urandom), ridx, rlim);
    endtask

    task automatic clear_all();
        send_word(kcct_pkg::MODE_CLEAR, 8'($urandom), 3'($urandom), 4'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
    endtask

    task automatic test_directed();
        clear_all();
        read_entry(3'd0, 4'd8);
        press(8'h00);
        press(8'hFF);
        press(8'hFF);            // already held
        release_key(8'h55);      // never held
        read_entry(3'd0, 4'd15);
        read_entry(3'd1, 4'd1);  // limit blocks
        read_entry(3'd7, 4'd0);
        release_key(8'h00);
        release_key(8'hFF);      // chord complete
        release_key(8'hFF);
        press(8'h00);            // listed already, not appended
        for (int k = 1; k <= 6; k++)
            press(8'(k * 37));
        press(8'h80);            // list full
        read_entry(3'd7, 4'd8);
        read_entry(3'd7, 4'd7);
        read_entry(3'd2, 4'd15);
        clear_all();
        read_entry(3'd0, 4'd15);
    endtask

    task automatic test_full_bitmap();
        for (int k = 0; k < kcct_pkg::KEYS; k++)
            press(8'(k));
        read_entry(3'd7, 4'd15);
        press(8'd200);
        for (int k = kcct_pkg::KEYS - 1; k >= 0; k--)
            release_key(8'(k));
        release_key(8'd0);
        read_entry(3'd5, 4'd6);
    endtask

    task automatic run_chord();
        logic [7:0] chord [$];
        logic [7:0] key;
        int         n;
        int         j;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
        begin
            key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            press(key);
            chord.push_back(key);
            case ($urandom_range(0, 7))
                0: read_entry(3'($urandom), 4'($urandom));
                1: press(chord[$urandom_range(0, chord.size() - 1)]);
                2: release_key(8'($urandom));
                default: ;
            endcase
            if ($urandom_range(0, 40) == 0)
                clear_all();
        end
        while (chord.size() != 0)
        begin
            j = $urandom_range(0, chord.size() - 1);
            release_key(chord[j]);
            chord.delete(j);
        end
        repeat ($urandom_range(0, 2))
            read_entry(3'($urandom), 4'($urandom));
    endtask

    task automatic test_random_chords(input int n_items);
        int base;
        base = sent_cnt;
        while (sent_cnt - base < n_items)
        begin
            if ($urandom_range(0, 5) == 0)
                clear_all();
            run_chord();
        end
    endtask

    task automatic test_drain_pause();
        repeat (3) run_chord();
        wait_drained();
        repeat (3) run_chord();
    endtask

    // result check and output back-pressure
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (expected_words.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result word %h", m_tdata);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.newly_held !== want.newly_held
                        || got.capture_done !== want.capture_done
                        || got.held_total !== want.held_total
                        || got.captured_total !== want.captured_total
                        || got.entry_key !== want.entry_key
                        || got.entry_valid !== want.entry_valid)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("mismatch: exp nh=%0d cd=%0d held=%0d capt=%0d key=%h ev=%0d",
                                     want.newly_held, want.capture_done, want.held_total,
                                     want.captured_total, want.entry_key, want.entry_valid);
                            $display("          got nh=%0d cd=%0d held=%0d capt=%0d key=%h ev=%0d",
                                     got.newly_held, got.capture_done, got.held_total,
                                     got.captured_total, got.entry_key, got.entry_valid);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WD_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        held_map     = '0;
        held_cnt     = 0;
        cap_cnt      = 0;
        foreach (cap_list[i])
            cap_list[i] = 8'd0;
        mismatch_cnt = 0;
        sent_cnt     = 0;
        stall_left   = 0;
        idle_cycles  = 0;
        idle_en      = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_bitmap();
        test_random_chords(600);
        test_drain_pause();
        test_random_chords(250);
        idle_en = 1'b0;
        test_random_chords(200);

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_cnt == 0 && expected_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
